### rtl/tmo_pkg.sv
package tmo_pkg;

    // Port field widths, fixed by the stream format.
    localparam int SAMPLE_W = 12;
    localparam int CHAN_W   = 4;
    localparam int DATA_W   = 16;
    localparam int USER_W   = 5;

    // Which address the sample store is read at in a given cycle.
    typedef enum logic [1:0] {
        RD_TOP,
        RD_NEXT,
        RD_SUM
    } rd_src_t;

    typedef struct packed {
        logic    accept;
        logic    ins_step;
        rd_src_t rd_src;
        logic    sum_read;
        logic    div_load;
        logic    div_step;
        logic    out_load;
        logic    out_fail;
    } cmd_t;

    typedef struct packed {
        logic in_failed;
        logic shift;
        logic last;
        logic sum_end;
        logic out_free;
    } stat_t;

endpackage

### rtl/tmo_ram.sv
module tmo_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 7
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tmo_ctrl.sv
module tmo_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  tmo_pkg::stat_t stat,
    output tmo_pkg::cmd_t  cmd
);

    import tmo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SUM,
        S_TAIL,
        S_DIV,
        S_OUT,
        S_FAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_src = RD_TOP;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = stat.in_failed ? S_FAIL : S_INS;
                end
            end
            S_INS:
            begin
                // Each cycle moves one larger entry up, or drops the new
                // sample into the gap and ends the insertion.
                cmd.ins_step = 1'b1;
                cmd.rd_src   = RD_NEXT;
                if (!stat.shift)
                begin
                    state_next = stat.last ? S_SUM : S_IDLE;
                end
            end
            S_SUM:
            begin
                cmd.sum_read = 1'b1;
                cmd.rd_src   = RD_SUM;
                if (stat.sum_end)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_fail = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

### rtl/tmo_dp.sv
module tmo_dp #(
    parameter int SAMPLES     = 7,
    parameter int TRIM        = 1,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmo_pkg::cmd_t                cmd,
    output tmo_pkg::stat_t               stat,
    input  logic [tmo_pkg::DATA_W-1:0]   s_tdata,
    input  logic [tmo_pkg::USER_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tmo_pkg::DATA_W-1:0]   m_tdata,
    output logic [tmo_pkg::USER_W-1:0]   m_tuser
);

    import tmo_pkg::*;

    localparam int ADDR_W    = $clog2(SAMPLES);
    localparam int EFF_TRIM  = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
    localparam int KEPT      = SAMPLES - 2 * EFF_TRIM;
    localparam int SUM_W     = SAMPLE_BITS + $clog2(SAMPLES);
    localparam int FIRST_IDX = EFF_TRIM;
    localparam int LAST_IDX  = SAMPLES - 1 - EFF_TRIM;
    localparam int RECIP_SH  = SUM_W + $clog2(KEPT);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint RECIP = ((longint'(1) << RECIP_SH) + longint'(KEPT) - longint'(1))
                               / longint'(KEPT);

    logic [SAMPLE_BITS-1:0] in_sample;
    logic [SAMPLE_BITS-1:0] key_reg;
    logic [ADDR_W-1:0]      j_reg;
    logic [ADDR_W-1:0]      count_reg;
    logic [CHAN_W-1:0]      chan_reg;
    logic [ADDR_W-1:0]      idx_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [SUM_W-1:0]       acc_next;
    logic                   pend_reg;
    logic [SUM_W-1:0]       quot_reg;
    logic [PROD_W-1:0]      prod;

    logic                   m_valid_reg;
    logic                   m_status_reg;
    logic [SAMPLE_W-1:0]    m_avg_reg;
    logic [CHAN_W-1:0]      m_tag_reg;

    logic                   wr_en;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;

    assign in_sample = SAMPLE_BITS'(s_tdata[SAMPLE_W-1:0]);

    // The store is kept in ascending order: a new sample walks down from
    // the top, moving each larger entry up by one place.
    assign stat.in_failed = s_tuser[0];
    assign stat.shift     = (j_reg != '0) && (rd_data > key_reg);
    assign stat.last      = (count_reg == ADDR_W'(SAMPLES - 1));
    assign stat.sum_end   = (idx_reg == ADDR_W'(LAST_IDX));
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign wr_en   = cmd.ins_step;
    assign wr_data = stat.shift ? rd_data : key_reg;

    always_comb
    begin
        unique case (cmd.rd_src)
            RD_TOP:  rd_addr = count_reg - ADDR_W'(1);
            RD_NEXT: rd_addr = j_reg - ADDR_W'(2);
            RD_SUM:  rd_addr = idx_reg;
            default: rd_addr = count_reg - ADDR_W'(1);
        endcase
    end

    tmo_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SAMPLES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (j_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign acc_next = pend_reg ? acc_reg + SUM_W'(rd_data) : acc_reg;

    // The kept count is fixed, so the mean is the sum times a rounded-up
    // reciprocal, shifted down. The reciprocal carries enough bits to give
    // the exact floor for every sum that fits in SUM_W bits.
    assign prod = PROD_W'(quot_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            chan_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.sum_read;
            if (cmd.accept)
            begin
                if (count_reg == '0)
                begin
                    chan_reg <= s_tuser[CHAN_W:1];
                end
                if (s_tuser[0])
                begin
                    count_reg <= '0;
                end
            end
            else if (cmd.ins_step && !stat.shift)
            begin
                count_reg <= stat.last ? '0 : count_reg + ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= in_sample;
            j_reg   <= count_reg;
            idx_reg <= ADDR_W'(FIRST_IDX);
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.ins_step && stat.shift)
            begin
                j_reg <= j_reg - ADDR_W'(1);
            end
            if (cmd.sum_read)
            begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end
        end
        if (cmd.div_load)
        begin
            quot_reg <= acc_next;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= SUM_W'(prod >> RECIP_SH);
        end
        if (cmd.out_load)
        begin
            m_status_reg <= cmd.out_fail;
            m_avg_reg    <= cmd.out_fail ? '0 : SAMPLE_W'(quot_reg);
            m_tag_reg    <= chan_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'(m_avg_reg);
    assign m_tuser  = {m_tag_reg, m_status_reg};

    a_fail_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && s_tuser[0] |=> count_reg == '0)
        else $error("failed conversion did not restart the reading");

    a_fail_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_status_reg |-> m_avg_reg == '0)
        else $error("abandoned reading carries a non-zero average");

    a_quot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && !cmd.out_fail |-> (quot_reg >> SAMPLE_BITS) == '0)
        else $error("mean exceeds the sample range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ADDR_W'(SAMPLES - 1))
        else $error("sample count ran past the reading length");

endmodule

### rtl/trimmed_mean_oversampler.sv
// Collects SAMPLES converter samples, one beat each, and after the last one
// returns the floor mean of the samples left once TRIM of the smallest and
// TRIM of the largest are dropped (TRIM is cut back so that at least one
// sample is kept), tagged with the channel of the first sample. A beat
// flagged as a failed conversion ends the reading at once with a failure
// beat (average zero) and collection starts again. Samples are kept in a
// small RAM in ascending order: each one is inserted as it arrives,
// moving each stored sample larger than it up by one place. The last
// sample of a reading is then followed by adding up the kept entries,
// one RAM read a cycle, multiplying the sum by the reciprocal of the
// kept count and registering the result; the input is not ready during
// all of this. A result waiting on the output does not block the next
// sample, but the next result (mean or failure) waits until it has been
// taken.
module trimmed_mean_oversampler #(
    parameter int SAMPLES     = 7,
    parameter int TRIM        = 1,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [tmo_pkg::DATA_W-1:0] s_tdata,   // sample[11:0], zero pad
    input  logic [tmo_pkg::USER_W-1:0] s_tuser,   // read_failed[0], channel[4:1]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tmo_pkg::DATA_W-1:0] m_tdata,   // average[11:0], zero pad
    output logic [tmo_pkg::USER_W-1:0] m_tuser    // status[0], channel_tag[4:1]
);

    import tmo_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tmo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmo_dp #(
        .SAMPLES     (SAMPLES),
        .TRIM        (TRIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
